// ===== hw/rtl/plti_pkg.sv =====
// Shared types and constants for the piecewise linear table interpolator.
// Used by plti_ctrl, plti_datapath and the top level; depends on nothing.
package plti_pkg;

  // Table geometry and code width of the stored wavelengths and transmissions.
  localparam int TABLE_DEPTH = 256;
  localparam int CODE_BITS   = 32;

  // One input word.
  typedef struct packed {
    logic        kind;
    logic        restart;
    logic [31:0] wave_code;
    logic [31:0] trans_code;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [16:0] relative_trans;
    logic        in_range;
    logic [8:0]  stored_count;
    logic        overflow;
  } out_word_t;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Result selection codes.
  localparam logic [1:0] RES_LOAD   = 2'd0;
  localparam logic [1:0] RES_ZERO   = 2'd1;
  localparam logic [1:0] RES_NOPEAK = 2'd2;
  localparam logic [1:0] RES_INTERP = 2'd3;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam int unsigned FRAC_BITS = 16;

  typedef struct packed {
    logic       capture;
    logic       load;
    logic       scan_start;
    logic       scan_step;
    logic       pair_latch;
    logic       mul_start;
    logic       mul_step;
    logic       div1_start;
    logic       div2_start;
    logic       div_step;
    logic       emit;
    logic [1:0] res_sel;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic at_end;
    logic first;
    logic mul_last;
    logic div_last;
    logic peak_zero;
  } stat_t;

endpackage

// ===== hw/rtl/piecewise_linear_table_interpolator.sv =====
// Top level of the piecewise linear table interpolator.
// Instantiates plti_ctrl and plti_datapath; types come from plti_pkg.
//
//   channel  ports                  handshake                     payload
//   input    start, busy, in_data   taken when start && !busy     plti_pkg::in_word_t
//   result   out_valid, out_data    one-cycle strobe, no stall    plti_pkg::out_word_t
//
// A load word is captured, written to the table memories unless full, and reported.
// A query word runs a linear scan of the table memory, one entry per cycle, that
// stops at the first stored wavelength above the query or at the end of the table;
// on a hit past the first entry it then runs the bit-serial multiplier and up to two
// passes of the shared restoring divider, one bit per cycle each.
// Reset is synchronous and clears the entry count and the running peak.
// The receiver cannot stall; busy stays high until the result word is issued.
module piecewise_linear_table_interpolator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  plti_pkg::in_word_t  in_data,
  output logic                out_valid,
  output plti_pkg::out_word_t out_data
);

  plti_pkg::cmd_t  cmd;
  plti_pkg::stat_t stat;

  // The controller sequences the scan, multiply and divide phases.
  plti_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_data.kind),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  // The datapath holds the tables, the count, the peak and the arithmetic.
  plti_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_word   (out_data),
    .out_strobe (out_valid)
  );

  // An accepted word always makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // Result words are never issued back to back.
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // An in-range query result never reports a dropped load.
  a_range_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.in_range) |-> !out_data.overflow)
    else $error("in_range and overflow both set");

  // A result above 1.0 in Q1.16 is never produced.
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.relative_trans <= plti_pkg::ONE_Q16))
    else $error("relative transmission above one");

endmodule

// ===== hw/rtl/plti_ctrl.sv =====
// Sequencer for the piecewise linear table interpolator.
// Depends on plti_pkg for the command and status structs.
module plti_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           in_kind,
  input  plti_pkg::stat_t stat,
  output plti_pkg::cmd_t  cmd,
  output logic           busy
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_SCAN0 = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_SUMY  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_DIV1S = 4'd6;
  localparam logic [3:0] S_DIV1  = 4'd7;
  localparam logic [3:0] S_MID   = 4'd8;
  localparam logic [3:0] S_DIV2  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_kind == plti_pkg::KIND_LOAD) ? S_LOAD : S_SCAN0;
        end
      end
      S_LOAD: begin
        cmd.load    = 1'b1;
        cmd.emit    = 1'b1;
        cmd.res_sel = plti_pkg::RES_LOAD;
        state_nxt   = S_IDLE;
      end
      S_SCAN0: begin
        cmd.scan_start = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        if (stat.at_end || (stat.hit && stat.first)) begin
          cmd.emit    = 1'b1;
          cmd.res_sel = plti_pkg::RES_ZERO;
          state_nxt   = S_IDLE;
        end else if (stat.hit) begin
          cmd.pair_latch = 1'b1;
          state_nxt      = S_SUMY;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SUMY: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_last) begin
          state_nxt = S_DIV1S;
        end
      end
      S_DIV1S: begin
        cmd.div1_start = 1'b1;
        state_nxt      = S_DIV1;
      end
      S_DIV1: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_MID;
        end
      end
      S_MID: begin
        if (stat.peak_zero) begin
          cmd.emit    = 1'b1;
          cmd.res_sel = plti_pkg::RES_NOPEAK;
          state_nxt   = S_IDLE;
        end else begin
          cmd.div2_start = 1'b1;
          state_nxt      = S_DIV2;
        end
      end
      S_DIV2: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.emit    = 1'b1;
        cmd.res_sel = plti_pkg::RES_INTERP;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/plti_datapath.sv =====
// Datapath of the piecewise linear table interpolator: table memories, scan,
// shift-add multiplier, shared restoring divider and result register. Uses plti_pkg.
module plti_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  plti_pkg::in_word_t  in_word,
  input  plti_pkg::cmd_t      cmd,
  output plti_pkg::stat_t     stat,
  output plti_pkg::out_word_t out_word,
  output logic                out_strobe
);

  localparam int TABLE_DEPTH = plti_pkg::TABLE_DEPTH;
  localparam int W   = plti_pkg::CODE_BITS;
  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int SW  = 2 * W + 1;
  localparam int QW  = W + 17;
  localparam int ITW = $clog2(2 * W + 2);

  logic [W-1:0] wave_mem  [TABLE_DEPTH];
  logic [W-1:0] trans_mem [TABLE_DEPTH];

  logic [W-1:0]   q_r, trans_in_r, peak_r;
  logic           restart_r;
  logic [CW-1:0]  count_r, rd_addr_r, cmp_idx_r;
  logic [W-1:0]   wave_rd_r, trans_rd_r, prev_wave_r, prev_trans_r;
  logic [W-1:0]   a_r, b_r, y1_r, y2_r, dvs_r, rem_r;
  logic [W:0]     y12_r;
  logic [SW-1:0]  acc_r;
  logic [QW-1:0]  quo_r;
  logic [ITW-1:0] iter_r;
  plti_pkg::out_word_t out_r, out_nxt;
  logic           out_strobe_r;

  logic [CW-1:0] cnt_eff, cnt_new;
  logic [W-1:0]  peak_eff;
  logic          full_eff;
  logic [W:0]    mul_sel, r2, r2_sub;
  logic          ge;
  logic [16:0]   rel_sat;

  // Load bookkeeping with the restart flag applied first.
  always_comb begin
    cnt_eff  = restart_r ? '0 : count_r;
    peak_eff = restart_r ? '0 : peak_r;
    full_eff = (cnt_eff >= CW'(TABLE_DEPTH));
    cnt_new  = full_eff ? cnt_eff : cnt_eff + CW'(1);
  end

  always_comb begin
    case ({a_r[W-1], b_r[W-1]})
      2'b11:   mul_sel = y12_r;
      2'b10:   mul_sel = {1'b0, y1_r};
      2'b01:   mul_sel = {1'b0, y2_r};
      default: mul_sel = '0;
    endcase
    r2      = {rem_r, acc_r[SW-1]};
    ge      = (r2 >= {1'b0, dvs_r});
    r2_sub  = r2 - {1'b0, dvs_r};
    rel_sat = (quo_r > QW'(plti_pkg::ONE_Q16)) ? plti_pkg::ONE_Q16 : quo_r[16:0];
  end

  // Result word assembled from the selected outcome.
  always_comb begin
    out_nxt = '0;
    case (cmd.res_sel)
      plti_pkg::RES_LOAD: begin
        out_nxt.stored_count = 9'(cnt_new);
        out_nxt.overflow     = full_eff;
      end
      plti_pkg::RES_NOPEAK: begin
        out_nxt.in_range     = 1'b1;
        out_nxt.stored_count = 9'(count_r);
      end
      plti_pkg::RES_INTERP: begin
        out_nxt.in_range       = 1'b1;
        out_nxt.relative_trans = rel_sat;
        out_nxt.stored_count   = 9'(count_r);
      end
      default: begin
        out_nxt.stored_count = 9'(count_r);
      end
    endcase
  end

  assign stat.hit       = (wave_rd_r > q_r);
  assign stat.at_end    = (cmp_idx_r >= count_r);
  assign stat.first     = (cmp_idx_r == '0);
  assign stat.mul_last  = (iter_r == ITW'(W - 1));
  assign stat.div_last  = (iter_r == ITW'(2 * W));
  assign stat.peak_zero = (peak_r == '0);

  // Table memories: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (cmd.load && !full_eff) begin
      wave_mem[cnt_eff[AW-1:0]]  <= q_r;
      trans_mem[cnt_eff[AW-1:0]] <= trans_in_r;
    end
    wave_rd_r  <= wave_mem[rd_addr_r[AW-1:0]];
    trans_rd_r <= trans_mem[rd_addr_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      peak_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit;
      if (cmd.load) begin
        count_r <= cnt_new;
        if (!full_eff && (trans_in_r > peak_eff)) begin
          peak_r <= trans_in_r;
        end else begin
          peak_r <= peak_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_r        <= W'(in_word.wave_code);
      trans_in_r <= W'(in_word.trans_code);
      restart_r  <= in_word.restart;
      rd_addr_r  <= '0;
    end
    if (cmd.scan_start) begin
      rd_addr_r <= CW'(1);
      cmp_idx_r <= '0;
    end
    if (cmd.scan_step) begin
      prev_wave_r  <= wave_rd_r;
      prev_trans_r <= trans_rd_r;
      rd_addr_r    <= rd_addr_r + CW'(1);
      cmp_idx_r    <= cmp_idx_r + CW'(1);
    end
    if (cmd.pair_latch) begin
      a_r   <= wave_rd_r - q_r;
      b_r   <= q_r - prev_wave_r;
      dvs_r <= wave_rd_r - prev_wave_r;
      y1_r  <= prev_trans_r;
      y2_r  <= trans_rd_r;
    end
    if (cmd.mul_start) begin
      y12_r  <= {1'b0, y1_r} + {1'b0, y2_r};
      acc_r  <= '0;
      iter_r <= '0;
    end
    if (cmd.mul_step) begin
      acc_r  <= {acc_r[SW-2:0], 1'b0} + SW'(mul_sel);
      a_r    <= {a_r[W-2:0], 1'b0};
      b_r    <= {b_r[W-2:0], 1'b0};
      iter_r <= iter_r + ITW'(1);
    end
    if (cmd.div1_start) begin
      rem_r  <= '0;
      quo_r  <= '0;
      iter_r <= '0;
    end
    if (cmd.div2_start) begin
      acc_r  <= SW'({quo_r[W-1:0], {plti_pkg::FRAC_BITS{1'b0}}});
      dvs_r  <= peak_r;
      rem_r  <= '0;
      quo_r  <= '0;
      iter_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= ge ? r2_sub[W-1:0] : r2[W-1:0];
      acc_r  <= {acc_r[SW-2:0], 1'b0};
      quo_r  <= {quo_r[QW-2:0], ge};
      iter_r <= iter_r + ITW'(1);
    end
    if (cmd.emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_word   = out_r;
  assign out_strobe = out_strobe_r;

endmodule
